// ----- design/lspm_pkg.sv -----
// Shared types, register indexes and constants of the laser scan proximity monitor.
package lspm_pkg;

  localparam int RANGE_W = 16;
  localparam int ANG_W   = 23;
  localparam int STEP_W  = 18;
  localparam int CONE_W  = 22;
  localparam int SHARE_W = 9;
  localparam int CNT_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CNT_W-1:0] MAX_RAYS = 13'd4096;

  localparam logic [RANGE_W-1:0] NONE_RANGE = 16'hFFFF;
  localparam logic [ANG_W-1:0]   ANG_MIN    = 23'h400000;
  localparam logic [ANG_W-1:0]   ANG_MAX    = 23'h3FFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONE_HALF     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_SHARE = 3'd7;

  localparam logic [RANGE_W-1:0] RANGE_FLOOR_RST   = 16'd0;
  localparam logic [RANGE_W-1:0] RANGE_CEILING_RST = 16'd65534;
  localparam logic [RANGE_W-1:0] WARNING_RST       = 16'd500;
  localparam logic [RANGE_W-1:0] CRITICAL_RST      = 16'd250;
  localparam logic [ANG_W-1:0]   START_ANGLE_RST   = -23'sd205887;
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST    = 18'd1144;
  localparam logic [CONE_W-1:0]  CONE_HALF_RST     = 22'd34315;
  localparam logic [SHARE_W-1:0] BLOCKED_SHARE_RST = 9'd154;

  localparam logic [1:0] LVL_CLEAR = 2'd0;
  localparam logic [1:0] LVL_WARN  = 2'd1;
  localparam logic [1:0] LVL_CRIT  = 2'd2;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               sample_valid;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic [RANGE_W-1:0] nearest_mm;
    logic [ANG_W-1:0]   nearest_angle;
    logic               found_any;
    logic [1:0]         proximity_level;
    logic               path_obstructed;
    logic [CNT_W-1:0]   cone_rays;
    logic [CNT_W-1:0]   cone_blocked_rays;
  } out_word_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_floor_mm;
    logic [RANGE_W-1:0] range_ceiling_mm;
    logic [RANGE_W-1:0] warning_mm;
    logic [RANGE_W-1:0] critical_mm;
    logic [ANG_W-1:0]   start_angle;
    logic [STEP_W-1:0]  angle_step;
    logic [CONE_W-1:0]  cone_half_width;
    logic [SHARE_W-1:0] blocked_share;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [ANG_W-1:0] value;
  } ang_load_t;

endpackage

// ----- design/laser_scan_proximity_monitor_core.sv -----
// Top level of the laser scan proximity monitor: input register, accumulator, result register.
// Words enter the input register; a last sample's result then goes to the result register.
// Throughput: one word per cycle; a last-sample word waits in the input register only
//   while the result register holds an untaken result.
// Reset: synchronous active-low rst_n restores register defaults and clears the scan state.
module laser_scan_proximity_monitor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lspm_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lspm_pkg::out_word_t             out_word,
  input  logic                            cfg_wr_en,
  input  logic [lspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lspm_pkg::*;

  cfg_t      cfg;
  ang_load_t ang_load;
  out_word_t res;

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      out_free;
  logic      proc;
  logic      in_acc;

  lspm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .ang_load  (ang_load)
  );

  lspm_scan_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ang_load (ang_load),
    .proc     (proc),
    .word     (s1_word_r),
    .res      (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && (!s1_word_r.last_sample || out_free);
  assign in_stall = s1_valid_r && !proc;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_word_r <= in_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s1_word_r.last_sample) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_word_r.last_sample) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(proc && s1_word_r.last_sample))
    else $error("pending result overwritten");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_word_r.last_sample |=> out_valid_r)
    else $error("last sample produced no result");

endmodule

// ----- design/lspm_cfg_regs.sv -----
// Configuration register file of the laser scan proximity monitor.
module lspm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lspm_pkg::cfg_t                cfg,
  output lspm_pkg::ang_load_t           ang_load
);
  import lspm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_floor_mm   <= RANGE_FLOOR_RST;
      cfg_r.range_ceiling_mm <= RANGE_CEILING_RST;
      cfg_r.warning_mm       <= WARNING_RST;
      cfg_r.critical_mm      <= CRITICAL_RST;
      cfg_r.start_angle      <= START_ANGLE_RST;
      cfg_r.angle_step       <= ANGLE_STEP_RST;
      cfg_r.cone_half_width  <= CONE_HALF_RST;
      cfg_r.blocked_share    <= BLOCKED_SHARE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RANGE_FLOOR:   cfg_r.range_floor_mm   <= cfg_wdata[RANGE_W-1:0];
        REG_RANGE_CEILING: cfg_r.range_ceiling_mm <= cfg_wdata[RANGE_W-1:0];
        REG_WARNING:       cfg_r.warning_mm       <= cfg_wdata[RANGE_W-1:0];
        REG_CRITICAL:      cfg_r.critical_mm      <= cfg_wdata[RANGE_W-1:0];
        REG_START_ANGLE:   cfg_r.start_angle      <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_STEP:    cfg_r.angle_step       <= cfg_wdata[STEP_W-1:0];
        REG_CONE_HALF:     cfg_r.cone_half_width  <= cfg_wdata[CONE_W-1:0];
        REG_BLOCKED_SHARE: cfg_r.blocked_share    <= cfg_wdata[SHARE_W-1:0];
      endcase
    end
  end

  assign cfg            = cfg_r;
  // start angle write restarts the ray angle sequence
  assign ang_load.load  = cfg_wr_en && (cfg_index == REG_START_ANGLE);
  assign ang_load.value = cfg_wdata[ANG_W-1:0];

endmodule

// ----- design/lspm_scan_acc.sv -----
// Per-scan accumulator: nearest return, ray angle, cone counts and scan summary.
module lspm_scan_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  lspm_pkg::cfg_t      cfg,
  input  lspm_pkg::ang_load_t ang_load,
  input  logic                proc,
  input  lspm_pkg::in_word_t  word,
  output lspm_pkg::out_word_t res
);
  import lspm_pkg::*;

  logic [RANGE_W-1:0] best_rng_r, best_rng_nxt;
  logic [ANG_W-1:0]   best_ang_r, best_ang_nxt;
  logic               any_r, any_nxt;
  logic [ANG_W-1:0]   ray_ang_r, ray_ang_nxt;
  logic [CNT_W-1:0]   cone_cnt_r, cone_cnt_nxt;
  logic [CNT_W-1:0]   blk_cnt_r, blk_cnt_nxt;

  logic [ANG_W:0]              ang_sum;
  logic [ANG_W-1:0]            ang_mag;
  logic                        qual;
  logic                        in_cone;
  logic                        take;
  logic [SHARE_W+CNT_W-1:0]    share_prod;
  logic [SHARE_W+CNT_W-1:0]    blk_scaled;
  logic [1:0]                  level;

  always_comb begin
    ang_sum = {ray_ang_r[ANG_W-1], ray_ang_r}
            + {{(ANG_W+1-STEP_W){cfg.angle_step[STEP_W-1]}}, cfg.angle_step};
    if (ang_sum[ANG_W] != ang_sum[ANG_W-1]) begin
      ray_ang_nxt = ang_sum[ANG_W] ? ANG_MIN : ANG_MAX;
    end else begin
      ray_ang_nxt = ang_sum[ANG_W-1:0];
    end

    ang_mag = ray_ang_r[ANG_W-1] ? (~ray_ang_r + 1'b1) : ray_ang_r;
    in_cone = ang_mag <= {1'b0, cfg.cone_half_width};
    qual    = word.sample_valid && (word.range_mm >= cfg.range_floor_mm)
              && (word.range_mm <= cfg.range_ceiling_mm);
    take    = qual && (!any_r || (word.range_mm < best_rng_r));

    best_rng_nxt = take ? word.range_mm : best_rng_r;
    best_ang_nxt = take ? ray_ang_r : best_ang_r;
    any_nxt      = any_r || qual;

    cone_cnt_nxt = cone_cnt_r;
    blk_cnt_nxt  = blk_cnt_r;
    if (qual && in_cone) begin
      if (cone_cnt_r < MAX_RAYS) cone_cnt_nxt = cone_cnt_r + 1'b1;
      if ((word.range_mm < cfg.warning_mm) && (blk_cnt_r < MAX_RAYS)) begin
        blk_cnt_nxt = blk_cnt_r + 1'b1;
      end
    end

    share_prod = cfg.blocked_share * cone_cnt_nxt;
    blk_scaled = {1'b0, blk_cnt_nxt, 8'd0};

    level = LVL_CLEAR;
    if (any_nxt) begin
      if (best_rng_nxt < cfg.critical_mm)     level = LVL_CRIT;
      else if (best_rng_nxt < cfg.warning_mm) level = LVL_WARN;
    end

    res.nearest_mm        = any_nxt ? best_rng_nxt : NONE_RANGE;
    res.nearest_angle     = any_nxt ? best_ang_nxt : '0;
    res.found_any         = any_nxt;
    res.proximity_level   = level;
    res.path_obstructed   = (cone_cnt_nxt != '0) && (blk_scaled >= share_prod);
    res.cone_rays         = cone_cnt_nxt;
    res.cone_blocked_rays = blk_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_rng_r <= NONE_RANGE;
      best_ang_r <= '0;
      any_r      <= 1'b0;
      ray_ang_r  <= START_ANGLE_RST;
      cone_cnt_r <= '0;
      blk_cnt_r  <= '0;
    end else if (ang_load.load) begin
      ray_ang_r <= ang_load.value;
    end else if (proc) begin
      if (word.last_sample) begin
        best_rng_r <= NONE_RANGE;
        best_ang_r <= '0;
        any_r      <= 1'b0;
        ray_ang_r  <= cfg.start_angle;
        cone_cnt_r <= '0;
        blk_cnt_r  <= '0;
      end else begin
        best_rng_r <= best_rng_nxt;
        best_ang_r <= best_ang_nxt;
        any_r      <= any_nxt;
        ray_ang_r  <= ray_ang_nxt;
        cone_cnt_r <= cone_cnt_nxt;
        blk_cnt_r  <= blk_cnt_nxt;
      end
    end
  end

  a_blk_le_cone: assert property (@(posedge clk) disable iff (!rst_n)
    blk_cnt_r <= cone_cnt_r)
    else $error("blocked count exceeds cone count");

  a_cone_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cone_cnt_r <= MAX_RAYS)
    else $error("cone count beyond saturation");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && word.last_sample && !ang_load.load |=> !any_r && (cone_cnt_r == '0))
    else $error("scan state not cleared after last sample");

endmodule
